### hw/rtl/shortest_remaining_time_scheduler_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the shortest-remaining-time scheduler
// Concurrent checks clocked on clk_i, with and without the reset guard.
// ---------------------------------------------------------------------------
`ifndef SHORTEST_REMAINING_TIME_SCHEDULER_CORE_DEFINES_SVH
`define SHORTEST_REMAINING_TIME_SCHEDULER_CORE_DEFINES_SVH

// checked only out of reset
`define SRTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define SRTS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hw/rtl/srts_pkg.sv
// ---------------------------------------------------------------------------
// srts_pkg
// Types and constants of the shortest-remaining-time scheduler.
// ---------------------------------------------------------------------------
package srts_pkg;

  localparam int unsigned MaxTasksDef = 128;

  localparam logic [23:0] ClockMax = 24'hFF_FFFF;
  localparam logic [30:0] SumMax   = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_LOADED   = 3'd0,
    ST_REJECTED = 3'd1,
    ST_RAN      = 3'd2,
    ST_IDLE_TK  = 3'd3,
    ST_ALL_DONE = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  typedef enum logic [3:0] {
    FSM_IDLE   = 4'b0001,
    FSM_SCAN   = 4'b0010,
    FSM_UPDATE = 4'b0100,
    FSM_DONE   = 4'b1000
  } fsm_e;

  typedef struct packed {
    logic [15:0] arrive;
    logic [15:0] burst;
    logic [15:0] remain;
  } task_t;

endpackage

### hw/rtl/shortest_remaining_time_scheduler_core.sv
// ---------------------------------------------------------------------------
// shortest_remaining_time_scheduler_core
// Preemptive shortest-remaining-time-first scheduler over a task memory.
// ---------------------------------------------------------------------------
// Tasks live in one memory (arrival, burst, remaining time per slot), read
// through a registered port. A load, clear or all-done tick passes its
// result from the res registers to the output register. A scheduling tick
// walks the N loaded slots through the single read port, one slot per
// cycle, then writes back the chosen slot, if any. One item is worked at a
// time; a finished result waits in the output register while the next item
// is taken and worked.
module shortest_remaining_time_scheduler_core
  import srts_pkg::*;
#(
  parameter int unsigned MAX_TASKS = MaxTasksDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  action_i,
  input  logic [15:0] arrival_time_i,
  input  logic [15:0] burst_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [6:0]  run_slot_o,
  output logic        switched_in_o,
  output logic        preempt_flag_o,
  output logic [6:0]  preempt_slot_o,
  output logic        finished_flag_o,
  output logic [23:0] tick_start_o,
  output logic [30:0] turnaround_total_o,
  output logic [30:0] waiting_total_o,
  output logic [7:0]  task_count_o
);

`include "shortest_remaining_time_scheduler_core_defines.svh"

  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  fsm_e           state_q, state_d;
  logic [CW-1:0]  loaded_q, loaded_d;
  logic [CW-1:0]  finished_q, finished_d;
  logic [23:0]    clock_q, clock_d;
  logic           last_valid_q, last_valid_d;
  logic [IW-1:0]  last_q, last_d;
  logic [30:0]    turn_q, turn_d;
  logic [30:0]    wait_q, wait_d;
  logic [CW-1:0]  scan_idx_q, scan_idx_d;
  logic           rd_vld_q, rd_vld_d;
  logic [IW-1:0]  rd_idx_q, rd_idx_d;
  logic           found_q, found_d;
  logic [IW-1:0]  best_idx_q, best_idx_d;
  task_t          best_q, best_d;

  status_e        res_status_q, res_status_d;
  logic [IW-1:0]  res_slot_q, res_slot_d;
  logic           res_sw_q, res_sw_d;
  logic           res_pf_q, res_pf_d;
  logic [IW-1:0]  res_ps_q, res_ps_d;
  logic           res_fin_q, res_fin_d;
  logic [23:0]    res_start_q, res_start_d;

  logic           out_valid_q, out_valid_d;
  status_e        out_status_q;
  logic [IW-1:0]  out_slot_q, out_ps_q;
  logic           out_sw_q, out_pf_q, out_fin_q;
  logic [23:0]    out_start_q;
  logic [30:0]    out_turn_q, out_wait_q;
  logic [CW-1:0]  out_count_q;
  logic           out_load;

  task_t          task_mem [MAX_TASKS];
  task_t          rd_data_q;
  logic           mem_we, mem_re;
  logic [IW-1:0]  mem_waddr, mem_raddr;
  task_t          mem_wdata;

  logic           in_acc, elig;
  logic [15:0]    new_remain;
  logic [24:0]    turn_val;
  logic [31:0]    wait_val;
  logic [32:0]    turn_sum, wait_sum;
  logic [23:0]    clock_inc;

  assign in_ready_o = (state_q == FSM_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == FSM_DONE) && (!out_valid_q || out_ready_i);

  assign elig = rd_vld_q && ({8'd0, rd_data_q.arrive} <= clock_q) &&
                (rd_data_q.remain != 16'd0) &&
                (!found_q || (rd_data_q.remain < best_q.remain));

  assign new_remain = best_q.remain - 16'd1;
  assign turn_val   = 25'(clock_q) + 25'd1 - 25'(best_q.arrive);
  assign wait_val   = 32'(turn_val) - 32'(best_q.burst);
  assign turn_sum   = 33'(turn_q) + 33'(turn_val);
  assign wait_sum   = 33'(wait_q) + 33'(wait_val);
  assign clock_inc  = (clock_q == ClockMax) ? clock_q : clock_q + 24'd1;

  always_comb begin
    state_d      = state_q;
    loaded_d     = loaded_q;
    finished_d   = finished_q;
    clock_d      = clock_q;
    last_valid_d = last_valid_q;
    last_d       = last_q;
    turn_d       = turn_q;
    wait_d       = wait_q;
    scan_idx_d   = scan_idx_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_sw_d     = res_sw_q;
    res_pf_d     = res_pf_q;
    res_ps_d     = res_ps_q;
    res_fin_d    = res_fin_q;
    res_start_d  = res_start_q;
    mem_we       = 1'b0;
    mem_waddr    = loaded_q[IW-1:0];
    mem_wdata    = '{arrive: arrival_time_i, burst: burst_length_i, remain: burst_length_i};
    mem_re       = 1'b0;
    mem_raddr    = scan_idx_q[IW-1:0];

    case (state_q)
      FSM_IDLE: begin
        if (in_acc) begin
          res_slot_d  = '0;
          res_sw_d    = 1'b0;
          res_pf_d    = 1'b0;
          res_ps_d    = '0;
          res_fin_d   = 1'b0;
          res_start_d = clock_q;
          case (action_i)
            ACT_LOAD: begin
              state_d = FSM_DONE;
              if ((burst_length_i == 16'd0) || (loaded_q >= CW'(MAX_TASKS))) begin
                res_status_d = ST_REJECTED;
              end else begin
                res_status_d = ST_LOADED;
                res_slot_d   = loaded_q[IW-1:0];
                mem_we       = 1'b1;
                loaded_d     = loaded_q + CW'(1);
              end
            end
            ACT_CLEAR: begin
              state_d      = FSM_DONE;
              res_status_d = ST_CLEARED;
              res_start_d  = '0;
              loaded_d     = '0;
              finished_d   = '0;
              clock_d      = '0;
              last_valid_d = 1'b0;
              last_d       = '0;
              turn_d       = '0;
              wait_d       = '0;
            end
            ACT_TICK: begin
              if ((loaded_q == '0) || (finished_q >= loaded_q)) begin
                state_d      = FSM_DONE;
                res_status_d = ST_ALL_DONE;
              end else begin
                state_d    = FSM_SCAN;
                scan_idx_d = '0;
                found_d    = 1'b0;
              end
            end
            default: begin
              state_d = FSM_IDLE;
            end
          endcase
        end
      end
      FSM_SCAN: begin
        if (scan_idx_q < loaded_q) begin
          mem_re     = 1'b1;
          rd_vld_d   = 1'b1;
          rd_idx_d   = scan_idx_q[IW-1:0];
          scan_idx_d = scan_idx_q + CW'(1);
        end else if (!rd_vld_q) begin
          state_d = FSM_UPDATE;
        end
        if (elig) begin
          found_d    = 1'b1;
          best_idx_d = rd_idx_q;
          best_d     = rd_data_q;
        end
      end
      FSM_UPDATE: begin
        state_d = FSM_DONE;
        clock_d = clock_inc;
        if (found_q) begin
          res_status_d = ST_RAN;
          res_slot_d   = best_idx_q;
          mem_we       = 1'b1;
          mem_waddr    = best_idx_q;
          mem_wdata    = '{arrive: best_q.arrive, burst: best_q.burst, remain: new_remain};
          if (!last_valid_q || (last_q != best_idx_q)) begin
            res_sw_d     = 1'b1;
            res_pf_d     = last_valid_q;
            res_ps_d     = last_valid_q ? last_q : '0;
            last_valid_d = 1'b1;
            last_d       = best_idx_q;
          end
          if (new_remain == 16'd0) begin
            res_fin_d    = 1'b1;
            finished_d   = finished_q + CW'(1);
            turn_d       = (turn_sum > 33'(SumMax)) ? SumMax : turn_sum[30:0];
            wait_d       = (wait_sum > 33'(SumMax)) ? SumMax : wait_sum[30:0];
            last_valid_d = 1'b0;
          end
        end else begin
          res_status_d = ST_IDLE_TK;
          last_valid_d = 1'b0;
        end
      end
      FSM_DONE: begin
        if (out_load) begin
          state_d = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      task_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= task_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSM_IDLE;
      loaded_q     <= '0;
      finished_q   <= '0;
      clock_q      <= '0;
      last_valid_q <= 1'b0;
      last_q       <= '0;
      turn_q       <= '0;
      wait_q       <= '0;
      scan_idx_q   <= '0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      loaded_q     <= loaded_d;
      finished_q   <= finished_d;
      clock_q      <= clock_d;
      last_valid_q <= last_valid_d;
      last_q       <= last_d;
      turn_q       <= turn_d;
      wait_q       <= wait_d;
      scan_idx_q   <= scan_idx_d;
      rd_vld_q     <= rd_vld_d;
      found_q      <= found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    best_idx_q   <= best_idx_d;
    best_q       <= best_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_sw_q     <= res_sw_d;
    res_pf_q     <= res_pf_d;
    res_ps_q     <= res_ps_d;
    res_fin_q    <= res_fin_d;
    res_start_q  <= res_start_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= res_slot_q;
      out_sw_q     <= res_sw_q;
      out_pf_q     <= res_pf_q;
      out_ps_q     <= res_ps_q;
      out_fin_q    <= res_fin_q;
      out_start_q  <= res_start_q;
      out_turn_q   <= turn_q;
      out_wait_q   <= wait_q;
      out_count_q  <= loaded_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = out_status_q;
  assign run_slot_o         = 7'(out_slot_q);
  assign switched_in_o      = out_sw_q;
  assign preempt_flag_o     = out_pf_q;
  assign preempt_slot_o     = 7'(out_ps_q);
  assign finished_flag_o    = out_fin_q;
  assign tick_start_o       = out_start_q;
  assign turnaround_total_o = out_turn_q;
  assign waiting_total_o    = out_wait_q;
  assign task_count_o       = 8'(out_count_q);

  `SRTS_ASSERT(a_fin_le_loaded, finished_q <= loaded_q, "finished count above loaded count")
  `SRTS_ASSERT(a_scan_bound, (state_q == FSM_SCAN) |-> (scan_idx_q <= loaded_q), "scan past table")
  `SRTS_ASSERT(a_last_loaded, last_valid_q |-> (CW'(last_q) < loaded_q), "running mark on empty slot")
  `SRTS_ASSERT(a_wb_loaded, ((state_q == FSM_UPDATE) && found_q) |-> (CW'(best_idx_q) < loaded_q), "writeback to unloaded slot")

endmodule

### bench/shortest_remaining_time_scheduler_core_tb.sv
// ----------------------------------------------------------------------------
// Shortest-remaining-time scheduler core testbench
// A queue-fed driver and a clocked monitor run items through the scheduler
// under random stalls on both sides. A behavioral scheduler predicts every
// result, and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler_core_tb;
  import srts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ActNone = 2'd3;
  localparam int unsigned MaxTasks = MaxTasksDef;
  localparam longint unsigned CycleLimit = 3_000_000;
  localparam int unsigned RandItems = 1950;

  typedef struct packed {
    logic [1:0]  act;
    logic [15:0] arr;
    logic [15:0] bur;
  } sched_item_t;

  typedef struct packed {
    status_e     status;
    logic [6:0]  run_slot;
    logic        sw;
    logic        pf;
    logic [6:0]  ps;
    logic        fin;
    logic [23:0] start;
    logic [30:0] turn_tot;
    logic [30:0] wait_tot;
    logic [7:0]  cnt;
  } sched_res_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  action_i = ACT_LOAD;
  logic [15:0] arrival_time_i = '0;
  logic [15:0] burst_length_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [6:0]  run_slot_o;
  logic        switched_in_o;
  logic        preempt_flag_o;
  logic [6:0]  preempt_slot_o;
  logic        finished_flag_o;
  logic [23:0] tick_start_o;
  logic [30:0] turnaround_total_o;
  logic [30:0] waiting_total_o;
  logic [7:0]  task_count_o;

  shortest_remaining_time_scheduler_core dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .action_i,
    .arrival_time_i,
    .burst_length_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .run_slot_o,
    .switched_in_o,
    .preempt_flag_o,
    .preempt_slot_o,
    .finished_flag_o,
    .tick_start_o,
    .turnaround_total_o,
    .waiting_total_o,
    .task_count_o
  );

  // scheduler state mirror
  logic [15:0] arr_tbl [MaxTasks];
  logic [15:0] rem_tbl [MaxTasks];
  logic [15:0] bur_tbl [MaxTasks];
  int unsigned n_loaded = 0;
  int unsigned n_done = 0;
  logic [23:0] now_clk = '0;
  bit          last_vld = 1'b0;
  int unsigned last_slot = 0;
  logic [30:0] turn_sum = '0;
  logic [30:0] wait_sum = '0;

  sched_item_t pend_q[$];
  sched_res_t  result_q[$];
  sched_item_t drv_item;
  sched_res_t  got_exp;

  bit          in_taken = 1'b0;
  int unsigned total_items = 0;
  int unsigned rand_cnt = 0;
  int unsigned sent_cnt = 0;
  int unsigned acc_cnt = 0;
  int unsigned rcv_cnt = 0;
  int unsigned n_err = 0;
  int unsigned n_ran = 0, n_idle = 0, n_alldone = 0, n_rej = 0, n_fin = 0, n_pre = 0;
  longint unsigned cyc = 0;

  function automatic logic [30:0] sat31(input logic [30:0] a, input longint b);
    longint s;
    s = longint'(a) + b;
    return (s > longint'(SumMax)) ? SumMax : s[30:0];
  endfunction

  task automatic srtf_predict(input logic [1:0] act, input logic [15:0] arr,
                              input logic [15:0] bur);
    sched_res_t  r;
    bit          found;
    int unsigned best;
    int unsigned i;
    longint      turn;
    logic [31:0] wt;
    if (act == ActNone) return;
    r = '0;
    r.start = now_clk;
    if (act == ACT_LOAD) begin
      if (bur == 16'd0 || n_loaded >= MaxTasks) begin
        r.status = ST_REJECTED;
        n_rej++;
      end else begin
        r.status = ST_LOADED;
        r.run_slot = n_loaded[6:0];
        arr_tbl[n_loaded] = arr;
        rem_tbl[n_loaded] = bur;
        bur_tbl[n_loaded] = bur;
        n_loaded++;
      end
    end else if (act == ACT_CLEAR) begin
      n_loaded = 0;
      n_done = 0;
      now_clk = '0;
      last_vld = 1'b0;
      last_slot = 0;
      turn_sum = '0;
      wait_sum = '0;
      r.start = '0;
      r.status = ST_CLEARED;
    end else if (n_loaded == 0 || n_done >= n_loaded) begin
      r.status = ST_ALL_DONE;
      n_alldone++;
    end else begin
      found = 1'b0;
      best = 0;
      for (i = 0; i < n_loaded; i++) begin
        if (arr_tbl[i] <= now_clk && rem_tbl[i] != 16'd0 &&
            (!found || rem_tbl[i] < rem_tbl[best])) begin
          found = 1'b1;
          best = i;
        end
      end
      if (found) begin
        r.status = ST_RAN;
        r.run_slot = best[6:0];
        n_ran++;
        if (!last_vld || last_slot != best) begin
          r.sw = 1'b1;
          if (last_vld && rem_tbl[last_slot] != 16'd0) begin
            r.pf = 1'b1;
            r.ps = last_slot[6:0];
            n_pre++;
          end
          last_vld = 1'b1;
          last_slot = best;
        end
        rem_tbl[best] = rem_tbl[best] - 16'd1;
        if (rem_tbl[best] == 16'd0) begin
          turn = longint'(now_clk) + 1 - longint'(arr_tbl[best]);
          // 32-bit wrap when the saturated clock leaves turnaround below burst
          wt = 32'(turn - longint'(bur_tbl[best]));
          r.fin = 1'b1;
          n_done++;
          n_fin++;
          turn_sum = sat31(turn_sum, turn);
          wait_sum = sat31(wait_sum, wt);
          last_vld = 1'b0;
        end
      end else begin
        r.status = ST_IDLE_TK;
        n_idle++;
        last_vld = 1'b0;
      end
      if (now_clk < ClockMax) now_clk = now_clk + 24'd1;
    end
    r.turn_tot = turn_sum;
    r.wait_tot = wait_sum;
    r.cnt = n_loaded[7:0];
    result_q.push_back(r);
  endtask

  task automatic cmp_field(input string fname, input longint unsigned want,
                           input longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
      n_err++;
    end
  endtask

  task automatic push_item(input logic [1:0] act, input logic [15:0] arr,
                           input logic [15:0] bur);
    sched_item_t it;
    it.act = act;
    it.arr = arr;
    it.bur = bur;
    pend_q.push_back(it);
    total_items++;
    if (act != ActNone) rand_cnt++;
  endtask

  task automatic push_ticks(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) push_item(ACT_TICK, 16'($urandom), 16'($urandom));
  endtask

  function automatic logic [15:0] rnd_arrival();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 70) return 16'($urandom_range(0, 20));
    if (p < 90) return 16'($urandom_range(0, 60));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rnd_burst();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 75) return 16'($urandom_range(1, 12));
    if (p < 83) return 16'd0;
    if (p < 93) return 16'($urandom);
    if (p < 96) return 16'hFFFF;
    return 16'd1;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cyc++;
    if (cyc > CycleLimit) begin
      $display("%0t: timeout, %0d results still pending", $time, result_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_taken) begin
        if (pend_q.size() != 0 &&
            ((sent_cnt >= 700 && sent_cnt < 1000) || $urandom_range(0, 99) >= 21)) begin
          drv_item = pend_q.pop_front();
          in_valid_i <= 1'b1;
          action_i <= drv_item.act;
          arrival_time_i <= drv_item.arr;
          burst_length_i <= drv_item.bur;
          sent_cnt++;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= (rcv_cnt >= 700 && rcv_cnt < 1000) || ($urandom_range(0, 99) >= 21);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rcv_cnt++;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected item, expected none actual status %0d", $time, status_o);
          n_err++;
        end else begin
          got_exp = result_q.pop_front();
          cmp_field("status", got_exp.status, status_o);
          cmp_field("run_slot", got_exp.run_slot, run_slot_o);
          cmp_field("switched_in", got_exp.sw, switched_in_o);
          cmp_field("preempt_flag", got_exp.pf, preempt_flag_o);
          cmp_field("preempt_slot", got_exp.ps, preempt_slot_o);
          cmp_field("finished_flag", got_exp.fin, finished_flag_o);
          cmp_field("tick_start", got_exp.start, tick_start_o);
          cmp_field("turnaround_total", got_exp.turn_tot, turnaround_total_o);
          cmp_field("waiting_total", got_exp.wait_tot, waiting_total_o);
          cmp_field("task_count", got_exp.cnt, task_count_o);
        end
      end
      in_taken = in_valid_i && in_ready_o;
      if (in_taken) begin
        acc_cnt++;
        srtf_predict(action_i, arrival_time_i, burst_length_i);
      end
    end
  end

  initial begin
    int unsigned ep;
    int unsigned k;
    int unsigned nsteps;
    int unsigned p;

    // directed
    push_item(ACT_TICK, 16'h0000, 16'h0000);
    push_item(ACT_LOAD, 16'h0000, 16'h0000);
    push_item(ACT_LOAD, 16'h0000, 16'd5);
    push_item(ACT_LOAD, 16'd2, 16'd2);
    push_item(ACT_LOAD, 16'hFFFF, 16'hFFFF);
    push_item(ActNone, 16'hFFFF, 16'hFFFF);
    push_ticks(5);
    push_item(ACT_LOAD, 16'h0000, 16'd1);
    push_ticks(4);
    push_item(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
    push_item(ACT_LOAD, 16'd3, 16'd2);
    push_item(ACT_LOAD, 16'd3, 16'd2);
    push_ticks(5);
    push_item(ACT_CLEAR, 16'h0000, 16'h0000);
    push_item(ACT_TICK, 16'hFFFF, 16'hFFFF);

    // random episodes
    ep = 0;
    while (rand_cnt < RandItems) begin
      if ($urandom_range(0, 99) < 85) push_item(ACT_CLEAR, 16'($urandom), 16'($urandom));
      if (ep % 40 == 5) begin
        push_item(ACT_CLEAR, 16'($urandom), 16'($urandom));
        for (k = 0; k < MaxTasks + 2; k++)
          push_item(ACT_LOAD, 16'($urandom_range(0, 10)), 16'($urandom_range(1, 6)));
        push_ticks(8);
      end else begin
        nsteps = $urandom_range(1, 10);
        for (k = 0; k < nsteps; k++) push_item(ACT_LOAD, rnd_arrival(), rnd_burst());
        nsteps = $urandom_range(10, 60);
        for (k = 0; k < nsteps; k++) begin
          p = $urandom_range(0, 99);
          if (p < 90) push_item(ACT_TICK, 16'($urandom), 16'($urandom));
          else if (p < 94) push_item(ACT_LOAD, rnd_arrival(), rnd_burst());
          else if (p < 97) push_item(ActNone, 16'($urandom), 16'($urandom));
          else push_item(ACT_LOAD, 16'($urandom), 16'd0);
        end
      end
      ep++;
    end

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (acc_cnt < total_items || result_q.size() != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);

    $display("%0d items, %0d episodes: %0d ran ticks, %0d idle, %0d all-done, %0d rejected",
             total_items, ep, n_ran, n_idle, n_alldone, n_rej);
    $display("%0d completions, %0d preemptions, %0d mismatches", n_fin, n_pre, n_err);
    if (n_err == 0 && result_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/srts_pkg.sv
hw/rtl/shortest_remaining_time_scheduler_core.sv
bench/shortest_remaining_time_scheduler_core_tb.sv
